// ----- sv/assert_macros.svh -----
// assertion macros of the checker file bbso_checker.sv
// each macro samples on the rising edge of i_clk and is held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge out of reset
`define BBSO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true at a sampled edge out of reset
`define BBSO_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- sv/bbso_pkg.sv -----
// shared types and constants of the bouncing ball sprite overlay
// used by every module of the block, no dependencies
package bbso_pkg;

    // register and field widths
    localparam int DIM_W        = 12;
    localparam int SIZE_W       = 10;
    localparam int OFFS_W       = 15;
    localparam int DATA_W       = 32;
    localparam int TIME_W       = 31;
    localparam int CORNER_OUT_W = 11;
    localparam int ADDR_W       = 5;
    localparam int REG_IDX_W    = 3;

    // time divide and position modulo
    localparam int DIVISOR     = 10;
    // divide by ten as a multiply by the reciprocal of ten scaled by 2^35, rounded up
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
    localparam int DIV_SHIFT   = 35;
    localparam int PROD_W      = TIME_W + RECIP_W;
    localparam int QUOT_W      = TIME_W - 3;
    localparam int SUM_W       = QUOT_W + 1;
    localparam int MOD_W       = DIM_W + 1;
    localparam int MOD_STEPS   = SUM_W;
    localparam int CNT_W       = $clog2(MOD_STEPS);

    // circle test
    localparam int RAD_W = SIZE_W - 1;
    localparam int DX_W  = SIZE_W + 1;
    localparam int SQ_W  = 2 * SIZE_W;
    localparam int RR_W  = 2 * RAD_W;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BALL_SIZE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BALL_COLOR   = 3'd5;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 12'd240;
    localparam logic [SIZE_W-1:0] RST_BALL_SIZE    = 10'd10;
    localparam logic [OFFS_W-1:0] RST_OFFSET       = 15'd0;
    localparam logic [DATA_W-1:0] RST_BALL_COLOR   = 32'hFFFF_FFFF;

    // operation and result codes
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [SIZE_W-1:0] ball_size;
        logic [OFFS_W-1:0] offset_x;
        logic [OFFS_W-1:0] offset_y;
        logic [DATA_W-1:0] ball_color;
    } t_cfg;

    typedef struct packed {
        logic load_time;
        logic div_step;
        logic mod_load;
        logic mod_step;
        logic fold;
        logic emit;
        logic take_pixel;
    } t_cmd;

    typedef struct packed {
        logic s1_free;
    } t_status;

endpackage

// ----- sv/bouncing_ball_sprite_overlay.sv -----
// top level of the bouncing ball sprite overlay
// depends on bbso_pkg, bbso_regs, bbso_ctrl and bbso_path
//
// Paints a round ball over a raster stream. Input beats are either a frame beat
// (operation 0, carries time_ms) or a pixel beat (operation 1, carries the
// background pixel at the current raster position). Every input beat yields
// exactly one output beat, in order. Pixel beats flow one per clock, while the
// first stage has room, through a three-register pipeline (square test and
// centre offsets, squares, compare and colour select), each result passing
// through them in order; the pipeline keeps filling while a finished result
// waits under i_stall. A frame beat occupies the block from its acceptance
// through one divide by ten done as a multiply by its reciprocal, one add of
// the axis offsets, a bit-serial modulo by twice the free span on both axes at
// once (29 steps), a fold and the hand-over of the frame result to the
// pipeline; o_stall stays high meanwhile, longer if the pipeline is full. The
// frame beat also restarts the raster at row 0, column 0, and its result
// carries the new ball corner.
// Registers sit on an apb port at byte address 4*index: image_width,
// image_height, ball_size, offset_x, offset_y, ball_color; write them only while
// no beat is in flight. MAX_DIM bounds corner and raster counters, PIXEL_BYTES
// sets how many low bytes of a pixel are kept.
module bouncing_ball_sprite_overlay #(
    parameter int MAX_DIM     = 2048,
    parameter int PIXEL_BYTES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic [bbso_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [bbso_pkg::DATA_W-1:0]          i_background_pixel,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_result_kind,
    output logic [bbso_pkg::DATA_W-1:0]          o_pixel_value,
    output logic                                 o_on_ball,
    output logic [bbso_pkg::CORNER_OUT_W-1:0]    o_ball_left,
    output logic [bbso_pkg::CORNER_OUT_W-1:0]    o_ball_top,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bbso_pkg::ADDR_W-1:0]          paddr,
    input  logic [bbso_pkg::DATA_W-1:0]          pwdata,
    output logic [bbso_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    bbso_pkg::t_cfg    cfg;
    bbso_pkg::t_cmd    cmd;
    bbso_pkg::t_status status;

    // configuration registers
    bbso_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake and frame sequencing
    bbso_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic, counters and pixel pipeline
    bbso_path #(
        .MAX_DIM     (MAX_DIM),
        .PIXEL_BYTES (PIXEL_BYTES)
    ) u_path (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_time_ms          (i_time_ms),
        .i_background_pixel (i_background_pixel),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_result_kind      (o_result_kind),
        .o_pixel_value      (o_pixel_value),
        .o_on_ball          (o_on_ball),
        .o_ball_left        (o_ball_left),
        .o_ball_top         (o_ball_top)
    );

endmodule

// ----- sv/bbso_regs.sv -----
// apb register file of the bouncing ball sprite overlay
// depends on bbso_pkg for the register map and the t_cfg type
module bbso_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbso_pkg::ADDR_W-1:0]   paddr,
    input  logic [bbso_pkg::DATA_W-1:0]   pwdata,
    output logic [bbso_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output bbso_pkg::t_cfg                o_cfg
);

    bbso_pkg::t_cfg                       r_cfg;
    logic [bbso_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                 wr_en;

    assign reg_idx = paddr[bbso_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= bbso_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height <= bbso_pkg::RST_IMAGE_HEIGHT;
            r_cfg.ball_size    <= bbso_pkg::RST_BALL_SIZE;
            r_cfg.offset_x     <= bbso_pkg::RST_OFFSET;
            r_cfg.offset_y     <= bbso_pkg::RST_OFFSET;
            r_cfg.ball_color   <= bbso_pkg::RST_BALL_COLOR;
        end else if (wr_en) begin
            unique case (reg_idx)
                bbso_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= pwdata[bbso_pkg::DIM_W-1:0];
                end
                bbso_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= pwdata[bbso_pkg::DIM_W-1:0];
                end
                bbso_pkg::REG_BALL_SIZE: begin
                    r_cfg.ball_size <= pwdata[bbso_pkg::SIZE_W-1:0];
                end
                bbso_pkg::REG_OFFSET_X: begin
                    r_cfg.offset_x <= pwdata[bbso_pkg::OFFS_W-1:0];
                end
                bbso_pkg::REG_OFFSET_Y: begin
                    r_cfg.offset_y <= pwdata[bbso_pkg::OFFS_W-1:0];
                end
                bbso_pkg::REG_BALL_COLOR: begin
                    r_cfg.ball_color <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    // read mux, unmapped addresses read zero
    always_comb begin
        unique case (reg_idx)
            bbso_pkg::REG_IMAGE_WIDTH:  prdata = bbso_pkg::DATA_W'(r_cfg.image_width);
            bbso_pkg::REG_IMAGE_HEIGHT: prdata = bbso_pkg::DATA_W'(r_cfg.image_height);
            bbso_pkg::REG_BALL_SIZE:    prdata = bbso_pkg::DATA_W'(r_cfg.ball_size);
            bbso_pkg::REG_OFFSET_X:     prdata = bbso_pkg::DATA_W'(r_cfg.offset_x);
            bbso_pkg::REG_OFFSET_Y:     prdata = bbso_pkg::DATA_W'(r_cfg.offset_y);
            bbso_pkg::REG_BALL_COLOR:   prdata = r_cfg.ball_color;
            default:                    prdata = '0;
        endcase
    end

endmodule

// ----- sv/bbso_ctrl.sv -----
// controller of the bouncing ball sprite overlay: input handshake and frame sequencing
// depends on bbso_pkg for the command and status structs and the step counts
module bbso_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_operation,
    output logic               o_stall,
    input  bbso_pkg::t_status  i_status,
    output bbso_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MOD  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam int CW = bbso_pkg::CNT_W;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          accept;

    assign o_stall = (r_state != ST_IDLE) || !i_status.s1_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == bbso_pkg::OP_FRAME) begin
                        o_cmd.load_time = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        o_cmd.take_pixel = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.mod_load = 1'b1;
                n_cnt          = CW'(bbso_pkg::MOD_STEPS - 1);
                n_state        = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FOLD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.s1_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bbso_path.sv -----
// datapath of the bouncing ball sprite overlay: divide and modulo units, corners,
// raster counters and the pixel pipeline; depends on bbso_pkg
module bbso_path #(
    parameter int MAX_DIM     = 2048,
    parameter int PIXEL_BYTES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bbso_pkg::t_cfg                       i_cfg,
    input  bbso_pkg::t_cmd                       i_cmd,
    output bbso_pkg::t_status                    o_status,
    input  logic [bbso_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [bbso_pkg::DATA_W-1:0]          i_background_pixel,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic                                 o_result_kind,
    output logic [bbso_pkg::DATA_W-1:0]          o_pixel_value,
    output logic                                 o_on_ball,
    output logic [bbso_pkg::CORNER_OUT_W-1:0]    o_ball_left,
    output logic [bbso_pkg::CORNER_OUT_W-1:0]    o_ball_top
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int PW    = 8 * PIXEL_BYTES;
    localparam int MW    = bbso_pkg::MOD_W;
    localparam int LW    = (CW + 1 > MW) ? CW + 1 : MW;
    localparam int TW    = bbso_pkg::TIME_W;
    localparam int PRW   = bbso_pkg::PROD_W;
    localparam int SW    = bbso_pkg::SUM_W;
    localparam int QW    = bbso_pkg::QUOT_W;
    localparam int DW    = bbso_pkg::DIM_W;
    localparam int ZW    = bbso_pkg::SIZE_W;
    localparam int AW    = bbso_pkg::RAD_W;
    localparam int XW    = bbso_pkg::DX_W;
    localparam int QSW   = bbso_pkg::SQ_W;
    localparam int RRW   = bbso_pkg::RR_W;

    // one restoring step of the modulo unit
    function automatic logic [MW-1:0] f_mod_rem(input logic [MW-1:0] rem,
                                                input logic          bit_in,
                                                input logic [MW-1:0] m);
        logic [MW:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, m}) begin
            trial = trial - {1'b0, m};
        end
        return trial[MW-1:0];
    endfunction

    // triangle fold and saturation of one axis
    function automatic logic [CW-1:0] f_fold(input logic [MW-1:0] rem,
                                             input logic [DW-1:0] span,
                                             input logic          ok);
        logic [MW-1:0] p;
        p = rem;
        if (p > MW'(span)) begin
            p = {span, 1'b0} - p;
        end
        if (!ok) begin
            return '0;
        end else if (LW'(p) > LW'(MAX_DIM - 1)) begin
            return CW'(MAX_DIM - 1);
        end else begin
            return CW'(p);
        end
    endfunction

    // frame position units
    logic [TW-1:0]  r_dvd;
    logic [PRW-1:0] div_prod;
    logic [SW-1:0]  r_sumx, r_sumy;
    logic [MW-1:0]  r_remx, r_remy;
    logic [DW-1:0]  r_spanx, r_spany;
    logic           r_okx, r_oky;

    // ball corner and raster position
    logic [CW-1:0]  r_cx, r_cy, r_col, r_row;
    logic [LW-1:0]  col_inc, row_inc, lim_w, lim_h;

    // pixel pipeline
    logic                  free_o, free2, free1;
    logic                  r_v1, r_v2, r_vo;
    logic                  r_kind1, r_kind2, r_okind;
    logic [PW-1:0]         r_pix1, r_pix2, r_opix;
    logic                  r_in1, r_in2, r_ohit;
    logic [CW-1:0]         r_cx1, r_cy1, r_cx2, r_cy2, r_ocx, r_ocy;
    logic signed [XW-1:0]  r_dx1, r_dy1;
    logic [AW-1:0]         r_rad1;
    logic [QSW-1:0]        r_sqx2, r_sqy2;
    logic [RRW-1:0]        r_rr2;

    logic [LW-1:0]          relc, relr;
    logic                   in_sq;
    logic signed [XW-1:0]   dx, dy;
    logic [AW-1:0]          rad;
    logic signed [2*XW-1:0] prodx, prody;
    logic [QSW:0]           dist2;
    logic                   hit;

    // divide by ten, one multiply by the reciprocal, quotient in the top bits
    assign div_prod = PRW'(r_dvd) * PRW'(bbso_pkg::DIV_RECIP);

    // raster wrap limits
    assign col_inc = LW'(r_col) + LW'(1'b1);
    assign row_inc = LW'(r_row) + LW'(1'b1);
    assign lim_w   = (LW'(i_cfg.image_width) < LW'(MAX_DIM)) ? LW'(i_cfg.image_width)
                                                               : LW'(MAX_DIM);
    assign lim_h   = (LW'(i_cfg.image_height) < LW'(MAX_DIM)) ? LW'(i_cfg.image_height)
                                                                : LW'(MAX_DIM);

    // square test and offsets from the ball centre
    assign relc  = LW'(r_col) - LW'(r_cx);
    assign relr  = LW'(r_row) - LW'(r_cy);
    assign in_sq = (r_col >= r_cx) && (r_row >= r_cy) &&
                   (relc < LW'(i_cfg.ball_size)) && (relr < LW'(i_cfg.ball_size));
    assign rad   = i_cfg.ball_size[ZW-1:1];
    assign dx    = $signed({1'b0, relc[ZW-1:0]}) - $signed(XW'(rad));
    assign dy    = $signed({1'b0, relr[ZW-1:0]}) - $signed(XW'(rad));

    assign prodx = r_dx1 * r_dx1;
    assign prody = r_dy1 * r_dy1;
    assign dist2 = {1'b0, r_sqx2} + {1'b0, r_sqy2};
    assign hit   = r_in2 && (dist2 < (QSW + 1)'(r_rr2));

    // stage enables, a stage moves when the one after it has room
    assign free_o = !r_vo || !i_stall;
    assign free2  = !r_v2 || free_o;
    assign free1  = !r_v1 || free2;
    assign o_status.s1_free = free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_vo  <= 1'b0;
        end else begin
            if (i_cmd.fold) begin
                r_cx  <= f_fold(r_remx, r_spanx, r_okx);
                r_cy  <= f_fold(r_remy, r_spany, r_oky);
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.take_pixel) begin
                if (col_inc >= lim_w) begin
                    r_col <= '0;
                    r_row <= (row_inc >= lim_h) ? '0 : CW'(row_inc);
                end else begin
                    r_col <= CW'(col_inc);
                end
            end
            if (free1) begin
                r_v1 <= i_cmd.take_pixel || i_cmd.emit;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // frame position units
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_time) begin
            r_dvd <= i_time_ms;
        end else if (i_cmd.div_step) begin
            r_dvd <= TW'(div_prod[bbso_pkg::DIV_SHIFT +: QW]);
        end
        if (i_cmd.mod_load) begin
            r_sumx  <= SW'(r_dvd[QW-1:0]) + SW'(i_cfg.offset_x);
            r_sumy  <= SW'(r_dvd[QW-1:0]) + SW'(i_cfg.offset_y);
            r_remx  <= '0;
            r_remy  <= '0;
            r_okx   <= i_cfg.image_width > DW'(i_cfg.ball_size);
            r_oky   <= i_cfg.image_height > DW'(i_cfg.ball_size);
            r_spanx <= i_cfg.image_width - DW'(i_cfg.ball_size);
            r_spany <= i_cfg.image_height - DW'(i_cfg.ball_size);
        end else if (i_cmd.mod_step) begin
            r_sumx <= {r_sumx[SW-2:0], 1'b0};
            r_sumy <= {r_sumy[SW-2:0], 1'b0};
            r_remx <= f_mod_rem(r_remx, r_sumx[SW-1], {r_spanx, 1'b0});
            r_remy <= f_mod_rem(r_remy, r_sumy[SW-1], {r_spany, 1'b0});
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_cx1   <= r_cx;
            r_cy1   <= r_cy;
            r_dx1   <= dx;
            r_dy1   <= dy;
            r_rad1  <= rad;
            if (i_cmd.emit) begin
                r_kind1 <= bbso_pkg::KIND_FRAME;
                r_pix1  <= '0;
                r_in1   <= 1'b0;
            end else begin
                r_kind1 <= bbso_pkg::KIND_PIXEL;
                r_pix1  <= PW'(i_background_pixel);
                r_in1   <= in_sq;
            end
        end
        if (free2) begin
            r_kind2 <= r_kind1;
            r_pix2  <= r_pix1;
            r_in2   <= r_in1;
            r_cx2   <= r_cx1;
            r_cy2   <= r_cy1;
            r_sqx2  <= QSW'(prodx);
            r_sqy2  <= QSW'(prody);
            r_rr2   <= r_rad1 * r_rad1;
        end
        if (free_o) begin
            r_okind <= r_kind2;
            r_ohit  <= hit;
            r_opix  <= hit ? PW'(i_cfg.ball_color) : r_pix2;
            r_ocx   <= r_cx2;
            r_ocy   <= r_cy2;
        end
    end

    assign o_valid       = r_vo;
    assign o_result_kind = r_okind;
    assign o_pixel_value = bbso_pkg::DATA_W'(r_opix);
    assign o_on_ball     = r_ohit;
    assign o_ball_left   = bbso_pkg::CORNER_OUT_W'(r_ocx);
    assign o_ball_top    = bbso_pkg::CORNER_OUT_W'(r_ocy);

endmodule

// ----- sv/bbso_checker.sv -----
// port-level checks of the bouncing ball sprite overlay, bound to the top level
// depends on bbso_pkg and assert_macros.svh
`include "assert_macros.svh"

module bbso_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic                                 o_result_kind,
    input  logic [bbso_pkg::DATA_W-1:0]          o_pixel_value,
    input  logic                                 o_on_ball
);

    // a stalled result stays offered
    `BBSO_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid, "output beat dropped under stall")

    // a stalled result keeps its pixel
    `BBSO_ASSERT(a_out_stable, o_valid && i_stall |=> $stable(o_pixel_value), "stalled pixel changed")

    // frame results carry no pixel and no hit
    `BBSO_NEVER(a_frame_clean, o_valid && (o_result_kind == bbso_pkg::KIND_FRAME) && ((o_pixel_value != '0) || o_on_ball), "frame result with pixel data")

    // a taken frame beat keeps the input stalled while the position is worked out
    `BBSO_ASSERT(a_frame_busy, i_valid && !o_stall && (i_operation == bbso_pkg::OP_FRAME) |=> o_stall, "input not stalled after frame beat")

endmodule

bind bouncing_ball_sprite_overlay bbso_checker u_bbso_checker (.*);

// ----- verif/tb_bouncing_ball_sprite_overlay.sv -----
// self-checking testbench of bouncing_ball_sprite_overlay
// needs bbso_pkg and the rtl of the block, nothing else
`timescale 1ns / 1ps

module tb_bouncing_ball_sprite_overlay;

    localparam int MAX_DIM       = 2048;
    localparam int PIXEL_BYTES   = 4;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_WAIT      = 8;
    localparam int RANDOM_BEATS  = 1500;
    // a frame beat holds the input until its ball corner is worked out, so this is generous
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int DW            = bbso_pkg::DATA_W;
    localparam int TW            = bbso_pkg::TIME_W;
    localparam int OW            = bbso_pkg::CORNER_OUT_W;
    localparam int IW            = bbso_pkg::REG_IDX_W;
    localparam logic [DW-1:0] PIXEL_MASK =
        (PIXEL_BYTES >= 4) ? '1 : DW'((64'd1 << (8 * PIXEL_BYTES)) - 1);

    // addresses past the register map, writes there must be dropped
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic          kind;
        logic [DW-1:0] pixel;
        logic          on_ball;
        logic [OW-1:0] left;
        logic [OW-1:0] top;
    } t_overlay_beat;

    // clock, reset and dut pins, every one the bench drives known from time zero
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_operation = bbso_pkg::OP_FRAME;
    logic [TW-1:0]                     i_time_ms = '0;
    logic [DW-1:0]                     i_background_pixel = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic                              o_result_kind;
    logic [DW-1:0]                     o_pixel_value;
    logic                              o_on_ball;
    logic [OW-1:0]                     o_ball_left;
    logic [OW-1:0]                     o_ball_top;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [bbso_pkg::ADDR_W-1:0]       paddr = '0;
    logic [DW-1:0]                     pwdata = '0;
    logic [DW-1:0]                     prdata;
    logic                              pready;

    // shadow of the register file
    logic [bbso_pkg::DIM_W-1:0]  img_w    = bbso_pkg::RST_IMAGE_WIDTH;
    logic [bbso_pkg::DIM_W-1:0]  img_h    = bbso_pkg::RST_IMAGE_HEIGHT;
    logic [bbso_pkg::SIZE_W-1:0] ball_sz  = bbso_pkg::RST_BALL_SIZE;
    logic [bbso_pkg::OFFS_W-1:0] offs_x   = bbso_pkg::RST_OFFSET;
    logic [bbso_pkg::OFFS_W-1:0] offs_y   = bbso_pkg::RST_OFFSET;
    logic [DW-1:0]               ball_col = bbso_pkg::RST_BALL_COLOR;

    // shadow of the ball corner and the raster position
    logic [OW-1:0] corner_x = '0;
    logic [OW-1:0] corner_y = '0;
    logic [OW-1:0] raster_col = '0;
    logic [OW-1:0] raster_row = '0;

    t_overlay_beat painted_q[$];
    t_overlay_beat due;
    int  errors = 0;
    int  beats_out = 0;
    int  sent_beats = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  back_to_back = 1'b0;
    bit  moved;

    bouncing_ball_sprite_overlay #(
        .MAX_DIM     (MAX_DIM),
        .PIXEL_BYTES (PIXEL_BYTES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_time_ms          (i_time_ms),
        .i_background_pixel (i_background_pixel),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_kind      (o_result_kind),
        .o_pixel_value      (o_pixel_value),
        .o_on_ball          (o_on_ball),
        .o_ball_left        (o_ball_left),
        .o_ball_top         (o_ball_top),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // triangle-wave motion on one axis: unfold, wrap at twice the free span, fold back
    function automatic logic [OW-1:0] fold_corner(longint unsigned t,
            longint unsigned dim, longint unsigned size, longint unsigned offs);
        longint unsigned span;
        longint unsigned p;
        if (dim <= size) return '0;     // ball at least as big as the image: stuck at 0
        span = dim - size;
        p = (t / bbso_pkg::DIVISOR + offs) % (2 * span);
        if (p > span) p = 2 * span - p;
        if (p > MAX_DIM - 1) p = MAX_DIM - 1;   // corner past the counters saturates
        return p[OW-1:0];
    endfunction

    function automatic int raster_limit(int dim);
        return (dim < MAX_DIM) ? dim : MAX_DIM;
    endfunction

    // frame beat: new corner, raster back to the first pixel
    function automatic t_overlay_beat place_ball(logic [TW-1:0] t);
        t_overlay_beat b;
        corner_x   = fold_corner(t, img_w, ball_sz, offs_x);
        corner_y   = fold_corner(t, img_h, ball_sz, offs_y);
        raster_col = '0;
        raster_row = '0;
        b.kind    = bbso_pkg::KIND_FRAME;
        b.pixel   = '0;
        b.on_ball = 1'b0;
        b.left    = corner_x;
        b.top     = corner_y;
        return b;
    endfunction

    // pixel beat: circle test at the current raster spot, then step the raster
    function automatic t_overlay_beat paint_pixel(logic [DW-1:0] bg);
        t_overlay_beat b;
        int col;
        int row;
        int rad;
        int dx;
        int dy;
        col = raster_col;
        row = raster_row;
        b.on_ball = 1'b0;
        if (col >= corner_x && row >= corner_y &&
            col - corner_x < ball_sz && row - corner_y < ball_sz) begin
            rad = ball_sz / 2;
            dx  = col - corner_x - rad;
            dy  = row - corner_y - rad;
            b.on_ball = (dx * dx + dy * dy < rad * rad);
        end
        b.kind  = bbso_pkg::KIND_PIXEL;
        b.pixel = (b.on_ball ? ball_col : bg) & PIXEL_MASK;
        b.left  = corner_x;
        b.top   = corner_y;
        // a zero image size wraps after every pixel
        col = col + 1;
        if (col >= raster_limit(img_w)) begin
            col = 0;
            row = row + 1;
            if (row >= raster_limit(img_h)) row = 0;
        end
        raster_col = OW'(col);
        raster_row = OW'(row);
        return b;
    endfunction

    function automatic void apply_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
        case (idx)
            bbso_pkg::REG_IMAGE_WIDTH:  img_w    = val[bbso_pkg::DIM_W-1:0];
            bbso_pkg::REG_IMAGE_HEIGHT: img_h    = val[bbso_pkg::DIM_W-1:0];
            bbso_pkg::REG_BALL_SIZE:    ball_sz  = val[bbso_pkg::SIZE_W-1:0];
            bbso_pkg::REG_OFFSET_X:     offs_x   = val[bbso_pkg::OFFS_W-1:0];
            bbso_pkg::REG_OFFSET_Y:     offs_y   = val[bbso_pkg::OFFS_W-1:0];
            bbso_pkg::REG_BALL_COLOR:   ball_col = val;
            default: ;        // unmapped index, dropped
        endcase
    endfunction

    function automatic logic [DW-1:0] reg_value(logic [IW-1:0] idx);
        case (idx)
            bbso_pkg::REG_IMAGE_WIDTH:  return DW'(img_w);
            bbso_pkg::REG_IMAGE_HEIGHT: return DW'(img_h);
            bbso_pkg::REG_BALL_SIZE:    return DW'(ball_sz);
            bbso_pkg::REG_OFFSET_X:     return DW'(offs_x);
            bbso_pkg::REG_OFFSET_Y:     return DW'(offs_y);
            default:                    return ball_col;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("%0t mismatch on %s at result %0d: got %0h, want %0h",
                 $time, what, beats_out, got, want);
        errors++;
    endtask

    // result side: compare every accepted beat with the oldest prediction,
    // draw the next stall, and feed the watchdog
    always @(posedge i_clk) begin
        moved = psel || (i_valid && !o_stall);
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (painted_q.size() == 0) begin
                report_mismatch("unexpected result", o_pixel_value, '0);
            end else begin
                due = painted_q.pop_front();
                if (o_result_kind !== due.kind)
                    report_mismatch("result_kind", o_result_kind, due.kind);
                if (o_pixel_value !== due.pixel)
                    report_mismatch("pixel_value", o_pixel_value, due.pixel);
                if (o_on_ball !== due.on_ball)
                    report_mismatch("on_ball", o_on_ball, due.on_ball);
                if (o_ball_left !== due.left)
                    report_mismatch("ball_left", o_ball_left, due.left);
                if (o_ball_top !== due.top)
                    report_mismatch("ball_top", o_ball_top, due.top);
            end
            beats_out++;
            stall_left = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // receiver back-pressure, moved on the falling edge
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // no beat and no register access for too long: the block is hung
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t watchdog: nothing moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input beat; valid stays high afterwards until the next negedge,
    // where the next send or a drain takes it over
    task automatic send_beat(logic op, logic [TW-1:0] t, logic [DW-1:0] bg);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_operation        <= op;
        i_time_ms          <= t;
        i_background_pixel <= bg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == bbso_pkg::OP_FRAME) painted_q.push_back(place_ball(t));
        else                          painted_q.push_back(paint_pixel(bg));
        sent_beats++;
    endtask

    // input quiet and every prediction answered: safe to touch registers
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (painted_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(logic [IW-1:0] idx);
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== reg_value(idx)) report_mismatch("register read", prdata, reg_value(idx));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int size);
        write_reg(bbso_pkg::REG_IMAGE_WIDTH, w);
        write_reg(bbso_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(bbso_pkg::REG_BALL_SIZE, size);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset register values; time at both ends of its range
    task automatic test_reset_defaults();
        send_beat(bbso_pkg::OP_FRAME, '0, $urandom());
        send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), '0);
        send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), '1);
        send_beat(bbso_pkg::OP_FRAME, '1, $urandom());
        send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), $urandom());
    endtask

    // every register written with junk in the upper bits and read back;
    // writes past the map must leave all of them alone
    task automatic test_register_access();
        logic [IW-1:0] idx;
        for (int i = bbso_pkg::REG_IMAGE_WIDTH; i <= bbso_pkg::REG_BALL_COLOR; i++) begin
            idx = IW'(i);
            write_reg(idx, $urandom());
        end
        for (int i = bbso_pkg::REG_IMAGE_WIDTH; i <= bbso_pkg::REG_BALL_COLOR; i++)
            read_reg(IW'(i));
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        for (int i = bbso_pkg::REG_IMAGE_WIDTH; i <= bbso_pkg::REG_BALL_COLOR; i++)
            read_reg(IW'(i));
    endtask

    // ball as big as the image: no free span, corner pinned at 0; run a
    // whole 3x3 frame and one pixel past it so both column and row wrap, black ball on white
    task automatic test_ball_fills_image();
        set_geometry(3, 3, 3);
        write_reg(bbso_pkg::REG_BALL_COLOR, '0);
        send_beat(bbso_pkg::OP_FRAME, TW'($urandom()), $urandom());
        repeat (10) send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), '1);
    endtask

    // zero image and zero ball: raster wraps after every pixel, never on the ball
    task automatic test_zero_sizes();
        set_geometry(0, 0, 0);
        send_beat(bbso_pkg::OP_FRAME, TW'($urandom()), $urandom());
        repeat (3) send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), $urandom());
    endtask

    // corner past the counter range saturates; then largest legal geometry
    task automatic test_corner_saturation();
        set_geometry(4095, 4095, 1);
        write_reg(bbso_pkg::REG_OFFSET_X, '0);
        write_reg(bbso_pkg::REG_OFFSET_Y, '0);
        write_reg(bbso_pkg::REG_BALL_COLOR, '1);
        send_beat(bbso_pkg::OP_FRAME, TW'(30000), $urandom());
        send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), $urandom());
        set_geometry(MAX_DIM, MAX_DIM, 1023);
        write_reg(bbso_pkg::REG_OFFSET_X, 32767);
        write_reg(bbso_pkg::REG_OFFSET_Y, 32767);
        send_beat(bbso_pkg::OP_FRAME, '1, $urandom());
        send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), $urandom());
    endtask

    // random small geometries; each frame beat followed by roughly a frame of
    // pixels so the ball gets drawn, sometimes cut short or run past the wrap
    task automatic test_random_frames();
        int phase;
        int w;
        int h;
        int lo;
        int size;
        int npix;
        phase = 0;
        sent_beats = 0;
        while (sent_beats < RANDOM_BEATS) begin
            w  = $urandom_range(3, 12);
            h  = $urandom_range(3, 12);
            lo = (w < h) ? w : h;
            case ($urandom_range(0, 9))
                0:       size = 0;
                1:       size = $urandom_range(lo, 2 * lo);
                default: size = $urandom_range(1, lo - 1);
            endcase
            set_geometry(w, h, size);
            case ($urandom_range(0, 3))
                0:       write_reg(bbso_pkg::REG_OFFSET_X, '0);
                1:       write_reg(bbso_pkg::REG_OFFSET_X, 32767);
                default: write_reg(bbso_pkg::REG_OFFSET_X, $urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(bbso_pkg::REG_OFFSET_Y, '0);
                1:       write_reg(bbso_pkg::REG_OFFSET_Y, 32767);
                default: write_reg(bbso_pkg::REG_OFFSET_Y, $urandom());
            endcase
            write_reg(bbso_pkg::REG_BALL_COLOR, $urandom());
            back_to_back = (phase % 3 == 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1))
                    send_beat(bbso_pkg::OP_FRAME, TW'($urandom()), $urandom());
                else
                    send_beat(bbso_pkg::OP_FRAME, TW'($urandom_range(0, 100000)), $urandom());
                npix = $urandom_range(w * h / 2, w * h + w);
                repeat (npix) send_beat(bbso_pkg::OP_PIXEL, TW'($urandom()), $urandom());
            end
            phase++;
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_access();
        test_ball_fills_image();
        test_zero_sizes();
        test_corner_saturation();
        test_random_frames();

        // let the last results out and make sure nothing extra follows
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
